### sv/rcm_pkg.sv
package rcm_pkg;

    // Channel map size; indexes at or beyond it pass through unmapped
    localparam int CHANNEL_COUNT = 16;

    // Field widths
    localparam int RX_W    = 11;
    localparam int PW_W    = 12;
    localparam int CH_W    = 4;
    localparam int CNT_W   = 16;
    localparam int PROD_W  = RX_W + PW_W;
    localparam int PADDR_W = 5;

    // Divider steps: the quotient never exceeds the pulse range
    localparam int DIV_STEPS = PW_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register map, word index
    localparam logic [2:0] REG_RX_MIN   = 3'd0;
    localparam logic [2:0] REG_RX_MAX   = 3'd1;
    localparam logic [2:0] REG_PW_MIN   = 3'd2;
    localparam logic [2:0] REG_PW_MAX   = 3'd3;
    localparam logic [2:0] REG_FLOOR    = 3'd4;
    localparam logic [2:0] REG_CEILING  = 3'd5;
    localparam logic [2:0] REG_TIMEOUT  = 3'd6;

    // Reset values
    localparam logic [RX_W-1:0]  RST_RX_MIN  = 11'd172;
    localparam logic [RX_W-1:0]  RST_RX_MAX  = 11'd1811;
    localparam logic [PW_W-1:0]  RST_PW_MIN  = 12'd1000;
    localparam logic [PW_W-1:0]  RST_PW_MAX  = 12'd2000;
    localparam logic [PW_W-1:0]  RST_FLOOR   = 12'd1000;
    localparam logic [PW_W-1:0]  RST_CEILING = 12'd2000;
    localparam logic [CNT_W-1:0] RST_TIMEOUT = 16'd1000;

    // Input operation codes (s_tuser)
    localparam logic OP_CHANNEL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### sv/rc_channel_map_with_failsafe.sv
// Channel   | Ports                           | Beat contents
// ----------+---------------------------------+-------------------------------------------
// input     | s_tvalid s_tready s_tdata       | tdata: channel_index, receiver_value
//           | s_tuser s_tlast                 | tuser: operation, tlast: frame_end
// result    | m_tvalid m_tready m_tdata       | tdata: out_channel, pulse_width, failsafe,
//           | m_tuser                         |        signal_seen; tuser: is_channel
// config    | psel penable pwrite paddr       | seven registers at byte address 4*index
//           | pwdata prdata pready            |
//
// A mapped channel passes through one multiply step, twelve restoring-divide steps on the
// shared subtract/compare unit and a finish step before the next beat is accepted.
// Ticks and unmapped channel indexes go straight from accept to the finish step.
// Synchronous active-low reset clears the sequencer, the silence state and the result valid.
// A result waits in the output register; a new beat is accepted meanwhile, and the
// finish step holds until the output register is free.
module rc_channel_map_with_failsafe #(
    parameter int CHANNEL_COUNT = rcm_pkg::CHANNEL_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [3:0] channel_index, [14:4] receiver_value
    input  logic                          s_tuser,   // [0] operation
    input  logic                          s_tlast,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [3:0] out_channel, [15:4] pulse_width,
                                                     // [16] failsafe, [17] signal_seen
    output logic                          m_tuser,   // [0] is_channel
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rcm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [RX_W-1:0]  rx_min_reg, rx_max_reg;
    logic [PW_W-1:0]  pw_min_reg, pw_max_reg, floor_reg, ceiling_reg;
    logic [CNT_W-1:0] timeout_reg;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_min_reg  <= RST_RX_MIN;
            rx_max_reg  <= RST_RX_MAX;
            pw_min_reg  <= RST_PW_MIN;
            pw_max_reg  <= RST_PW_MAX;
            floor_reg   <= RST_FLOOR;
            ceiling_reg <= RST_CEILING;
            timeout_reg <= RST_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RX_MIN:  rx_min_reg  <= pwdata[RX_W-1:0];
                REG_RX_MAX:  rx_max_reg  <= pwdata[RX_W-1:0];
                REG_PW_MIN:  pw_min_reg  <= pwdata[PW_W-1:0];
                REG_PW_MAX:  pw_max_reg  <= pwdata[PW_W-1:0];
                REG_FLOOR:   floor_reg   <= pwdata[PW_W-1:0];
                REG_CEILING: ceiling_reg <= pwdata[PW_W-1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_RX_MIN:  prdata = 32'(rx_min_reg);
            REG_RX_MAX:  prdata = 32'(rx_max_reg);
            REG_PW_MIN:  prdata = 32'(pw_min_reg);
            REG_PW_MAX:  prdata = 32'(pw_max_reg);
            REG_FLOOR:   prdata = 32'(floor_reg);
            REG_CEILING: prdata = 32'(ceiling_reg);
            REG_TIMEOUT: prdata = 32'(timeout_reg);
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------- input decode ----------------
    logic [CH_W-1:0] in_ch;
    logic [RX_W-1:0] in_raw;
    logic            in_op;
    logic            s_fire;
    logic            in_mapped;

    assign in_ch     = s_tdata[3:0];
    assign in_raw    = s_tdata[14:4];
    assign in_op     = s_tuser;
    assign s_fire    = s_tvalid && s_tready;
    assign in_mapped = (in_op == OP_CHANNEL) && (32'(in_ch) < CHANNEL_COUNT);

    // ---------------- sequencer ----------------
    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = in_mapped ? ST_MUL : ST_DONE;
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == '0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        step_next = step_reg;
        unique case (state_reg)
            ST_MUL:  step_next = STEP_W'(DIV_STEPS - 1);
            ST_DIV:  step_next = step_reg - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ---------------- operand preparation at accept ----------------
    logic [RX_W-1:0]        v_lo, v_clamp;
    logic signed [RX_W:0]   d_s, span_s;
    logic signed [PW_W:0]   dp_s;
    logic [RX_W-1:0]        d_mag_next, span_mag_next;
    logic [PW_W-1:0]        dp_mag_next;

    always_comb begin
        // raise to the minimum, then lower to the maximum
        v_lo    = (in_raw < rx_min_reg) ? rx_min_reg : in_raw;
        v_clamp = (v_lo > rx_max_reg) ? rx_max_reg : v_lo;
        d_s     = $signed({1'b0, v_clamp}) - $signed({1'b0, rx_min_reg});
        span_s  = $signed({1'b0, rx_max_reg}) - $signed({1'b0, rx_min_reg});
        dp_s    = $signed({1'b0, pw_max_reg}) - $signed({1'b0, pw_min_reg});
        d_mag_next    = d_s[RX_W]    ? RX_W'(-d_s)    : d_s[RX_W-1:0];
        span_mag_next = span_s[RX_W] ? RX_W'(-span_s) : span_s[RX_W-1:0];
        dp_mag_next   = dp_s[PW_W]   ? PW_W'(-dp_s)   : dp_s[PW_W-1:0];
    end

    logic [RX_W-1:0] d_mag_reg, span_mag_reg;
    logic [PW_W-1:0] dp_mag_reg;
    logic            neg_reg, span_zero_reg, is_ch_reg;
    logic [CH_W-1:0] ch_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            d_mag_reg     <= d_mag_next;
            span_mag_reg  <= span_mag_next;
            dp_mag_reg    <= dp_mag_next;
            // quotient sign from all three signed operands
            neg_reg       <= d_s[RX_W] ^ dp_s[PW_W] ^ span_s[RX_W];
            span_zero_reg <= (span_s == '0);
            is_ch_reg     <= in_mapped;
            ch_reg        <= (in_op == OP_CHANNEL) ? in_ch : '0;
        end
    end

    // ---------------- multiply, then shared subtract/compare divide ----------------
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] dsh_reg, dsh_next;
    logic [PW_W-1:0]   q_reg, q_next;
    logic              div_ge;

    assign div_ge = (rem_reg >= dsh_reg);

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        unique case (state_reg)
            ST_MUL: begin
                rem_next = PROD_W'(d_mag_reg) * PROD_W'(dp_mag_reg);
                dsh_next = PROD_W'(span_mag_reg) << (DIV_STEPS - 1);
                q_next   = '0;
            end
            ST_DIV: begin
                if (div_ge) rem_next = rem_reg - dsh_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[PW_W-2:0], div_ge};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    // ---------------- finish: sign, offset, channel limits ----------------
    logic signed [PW_W+1:0] q_s, p_raw, p_lim, lim_lo, lim_hi;
    logic [PW_W-1:0]        pw_final;

    always_comb begin
        q_s    = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        lim_lo = $signed({2'b00, floor_reg});
        lim_hi = $signed({2'b00, ceiling_reg});
        if (span_zero_reg) p_raw = $signed({2'b00, pw_min_reg});
        else               p_raw = $signed({2'b00, pw_min_reg}) + q_s;
        priority if (p_raw < lim_lo) p_lim = lim_lo;
        else if (p_raw > lim_hi)     p_lim = lim_hi;
        else                         p_lim = p_raw;
        pw_final = is_ch_reg ? p_lim[PW_W-1:0] : '0;
    end

    // ---------------- silence counter and failsafe latch ----------------
    logic [CNT_W-1:0] silence_reg, silence_next;
    logic             seen_reg, seen_next, fs_reg, fs_next;

    always_comb begin
        silence_next = silence_reg;
        seen_next    = seen_reg;
        if (s_fire) begin
            if (in_op == OP_TICK) begin
                if (silence_reg != '1) silence_next = silence_reg + 1'b1;
            end else if (s_tlast) begin
                silence_next = '0;
                seen_next    = 1'b1;
            end
        end
        // timeout is checked only when a beat is taken
        fs_next = fs_reg || (s_fire && seen_next && (silence_next >= timeout_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_reg <= '0;
            seen_reg    <= 1'b0;
            fs_reg      <= 1'b0;
        end else begin
            silence_reg <= silence_next;
            seen_reg    <= seen_next;
            fs_reg      <= fs_next;
        end
    end

    // ---------------- output register ----------------
    logic [23:0] m_data_reg;
    logic        m_user_reg;
    logic        out_load;

    assign out_load = (state_reg == ST_DONE) && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load)      m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {6'd0, seen_reg, fs_reg, pw_final, ch_reg};
            m_user_reg <= is_ch_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- assertions ----------------
    a_fs_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(fs_reg))
        else $error("failsafe latch cleared");

    a_fs_needs_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        fs_reg |-> seen_reg)
        else $error("failsafe latched without a frame");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) && (step_reg != '0) |=> (state_reg == ST_DIV))
        else $error("divider left early");

    a_tick_short: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (in_op == OP_TICK) |=> (state_reg == ST_DONE))
        else $error("tick did not go straight to finish");

    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_user_reg |-> (m_data_reg[15:4] == '0))
        else $error("pulse width on a non-channel result");

endmodule

### bench/rc_channel_map_with_failsafe_tb.sv
`timescale 1ns / 1ps

module rc_channel_map_with_failsafe_tb;

    import rcm_pkg::*;

    // One result beat, as seen on m_tdata / m_tuser
    typedef struct packed {
        logic            signal_seen;
        logic            failsafe;
        logic [PW_W-1:0] pulse_width;
        logic [CH_W-1:0] out_channel;
        logic            is_channel;
    } rc_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // [3:0] channel_index, [14:4] receiver_value
    logic                s_tuser;   // [0] operation
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;   // [3:0] out_channel, [15:4] pulse_width,
                                    // [16] failsafe, [17] signal_seen
    logic                m_tuser;   // [0] is_channel
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Mapper settings as last programmed
    logic [RX_W-1:0]  rx_lo;
    logic [RX_W-1:0]  rx_hi;
    logic [PW_W-1:0]  pw_lo;
    logic [PW_W-1:0]  pw_hi;
    logic [PW_W-1:0]  lim_lo;
    logic [PW_W-1:0]  lim_hi;
    logic [CNT_W-1:0] timeout_ms;

    // Silence tracking state of the predictor
    logic [CNT_W-1:0] silence_ms;
    logic             frame_seen;
    logic             failsafe_set;

    rc_result_t pending_results[$];
    int         mismatch_count;
    int         beats_sent;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         stall_hold_cycles;

    rc_channel_map_with_failsafe DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

    // Clamp to the receiver range, scale into the pulse range, then limit
    function automatic logic [PW_W-1:0] map_pulse(input logic [RX_W-1:0] raw);
        int v;
        int span;
        int p;
        v = int'(raw);
        if (v < int'(rx_lo)) v = int'(rx_lo);
        if (v > int'(rx_hi)) v = int'(rx_hi);
        span = int'(rx_hi) - int'(rx_lo);
        if (span == 0)
            p = int'(pw_lo);
        else
            p = int'(pw_lo) + ((v - int'(rx_lo)) * (int'(pw_hi) - int'(pw_lo))) / span;
        if (p < int'(lim_lo))
            p = int'(lim_lo);
        else if (p > int'(lim_hi))
            p = int'(lim_hi);
        return p[PW_W-1:0];
    endfunction

    // Advance the predictor by one accepted beat and queue its result
    task automatic predict_beat(input logic op, input logic [CH_W-1:0] idx,
                                input logic [RX_W-1:0] raw, input logic last);
        rc_result_t r;
        r = '0;
        if (op == OP_CHANNEL) begin
            r.out_channel = idx;
            if (idx < CHANNEL_COUNT) begin
                r.is_channel  = 1'b1;
                r.pulse_width = map_pulse(raw);
            end
            if (last) begin
                silence_ms = '0;
                frame_seen = 1'b1;
            end
        end else if (silence_ms != '1) begin
            silence_ms = silence_ms + 1'b1;
        end
        if (frame_seen && silence_ms >= timeout_ms)
            failsafe_set = 1'b1;
        r.failsafe    = failsafe_set;
        r.signal_seen = frame_seen;
        pending_results.push_back(r);
    endtask

    // Offer one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic op, input logic [CH_W-1:0] idx,
                             input logic [RX_W-1:0] raw, input logic last);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, raw, idx};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_beat(op, idx, raw, last);
        beats_sent++;
    endtask

    // Tick with random content in the ignored fields
    task automatic send_tick();
        send_beat(OP_TICK, CH_W'($urandom), RX_W'($urandom), 1'($urandom));
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write one register, then read it back
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_RX_MIN: begin
                rx_lo = value[RX_W-1:0];
                stored = 32'(rx_lo);
            end
            REG_RX_MAX: begin
                rx_hi = value[RX_W-1:0];
                stored = 32'(rx_hi);
            end
            REG_PW_MIN: begin
                pw_lo = value[PW_W-1:0];
                stored = 32'(pw_lo);
            end
            REG_PW_MAX: begin
                pw_hi = value[PW_W-1:0];
                stored = 32'(pw_hi);
            end
            REG_FLOOR: begin
                lim_lo = value[PW_W-1:0];
                stored = 32'(lim_lo);
            end
            REG_CEILING: begin
                lim_hi = value[PW_W-1:0];
                stored = 32'(lim_hi);
            end
            REG_TIMEOUT: begin
                timeout_ms = value[CNT_W-1:0];
                stored = 32'(timeout_ms);
            end
            default: stored = '0;
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // read-back, setup then access
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored) begin
            mismatch_count++;
            $display("%0t: register %0d read-back: expected %0d actual %0d",
                     $time, idx, stored, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Full register set, written only once the block is idle
    task automatic set_config(input int rmin, input int rmax, input int pmin, input int pmax,
                              input int flo, input int fhi, input int tmo);
        drain();
        program_reg(REG_RX_MIN, rmin);
        program_reg(REG_RX_MAX, rmax);
        program_reg(REG_PW_MIN, pmin);
        program_reg(REG_PW_MAX, pmax);
        program_reg(REG_FLOOR, flo);
        program_reg(REG_CEILING, fhi);
        program_reg(REG_TIMEOUT, tmo);
    endtask

    // Receiver value that often lands on or next to a range edge
    function automatic logic [RX_W-1:0] pick_raw();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return rx_lo;
            3: return rx_hi;
            4: return rx_lo + RX_W'($urandom_range(3)) - 1'b1;
            5: return rx_hi + RX_W'($urandom_range(3)) - 1'b1;
            default: return RX_W'($urandom_range(2047));
        endcase
    endfunction

    // Channels in order from a random start; a broken frame drops or misplaces its end
    task automatic send_frame(input bit broken);
        int n;
        int k;
        logic [CH_W-1:0] idx;
        n = ($urandom_range(3) == 0) ? CHANNEL_COUNT : $urandom_range(1, 6);
        idx = CH_W'($urandom);
        for (k = 0; k < n; k++) begin
            if (broken)
                send_beat(OP_CHANNEL, idx, pick_raw(), ($urandom_range(4) == 0));
            else
                send_beat(OP_CHANNEL, idx, pick_raw(), (k == n - 1));
            idx++;
        end
    endtask

    // Random settings; mostly ordered ranges, sometimes inverted or at the extremes
    task automatic random_config();
        int a, b, c, d, e, f, t;
        a = $urandom_range(2047);
        b = $urandom_range(2047);
        if ($urandom_range(4) != 0 && a > b) begin
            t = a; a = b; b = t;
        end
        if ($urandom_range(5) == 0) begin
            a = 0; b = 2047;
        end
        c = $urandom_range(4095);
        d = $urandom_range(4095);
        if ($urandom_range(4) != 0 && c > d) begin
            t = c; c = d; d = t;
        end
        if ($urandom_range(5) == 0) begin
            c = 0; d = 4095;
        end
        e = $urandom_range(4095);
        f = $urandom_range(4095);
        if ($urandom_range(4) != 0 && e > f) begin
            t = e; e = f; f = t;
        end
        case ($urandom_range(3))
            0: begin e = 0; f = 4095; end
            1: begin e = c; f = d; end
            default: ;
        endcase
        t = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1000, 65535);
        set_config(a, b, c, d, e, f, t);
    endtask

    // Silence before any frame must never trip the failsafe, even past a short timeout
    task automatic test_ticks_without_signal();
        int k;
        drain();
        program_reg(REG_TIMEOUT, 32'd20);
        for (k = 0; k < 60; k++) send_tick();
        drain();
        program_reg(REG_TIMEOUT, 32'(RST_TIMEOUT));
    endtask

    // Range edges at reset settings, then each corner of the settings
    task automatic test_directed_mapping();
        send_beat(OP_CHANNEL, 4'd0, 11'd0, 1'b0);
        send_beat(OP_TICK, 4'd15, 11'd2047, 1'b1);
        send_beat(OP_CHANNEL, 4'd15, 11'd2047, 1'b0);
        send_beat(OP_CHANNEL, 4'd5, 11'd172, 1'b0);
        send_beat(OP_CHANNEL, 4'd6, 11'd1811, 1'b0);
        send_beat(OP_CHANNEL, 4'd7, 11'd991, 1'b1);
        // zero receiver span
        set_config(1024, 1024, 1000, 2000, 1000, 2000, 1000);
        send_beat(OP_CHANNEL, 4'd1, 11'd0, 1'b0);
        send_beat(OP_CHANNEL, 4'd2, 11'd2047, 1'b1);
        // inverted receiver range
        set_config(2047, 0, 1000, 2000, 1000, 2000, 1000);
        send_beat(OP_CHANNEL, 4'd3, 11'd500, 1'b1);
        // inverted pulse range
        set_config(0, 2047, 4095, 0, 0, 4095, 1000);
        send_beat(OP_CHANNEL, 4'd8, 11'd0, 1'b0);
        send_beat(OP_CHANNEL, 4'd9, 11'd1000, 1'b0);
        send_beat(OP_CHANNEL, 4'd10, 11'd2047, 1'b1);
        // floor above ceiling
        set_config(172, 1811, 1000, 2000, 1800, 1200, 1000);
        send_beat(OP_CHANNEL, 4'd11, 11'd172, 1'b0);
        send_beat(OP_CHANNEL, 4'd12, 11'd1811, 1'b0);
        send_beat(OP_CHANNEL, 4'd13, 11'd991, 1'b1);
        // widest ranges, shortest timeout; no ticks so the latch stays clear
        set_config(0, 2047, 0, 4095, 0, 4095, 1);
        send_beat(OP_CHANNEL, 4'd14, 11'd0, 1'b1);
        send_beat(OP_CHANNEL, 4'd4, 11'd1024, 1'b1);
        send_beat(OP_CHANNEL, 4'd15, 11'd2047, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        int k;
        set_config(172, 1811, 1000, 2000, 1000, 2000, 1000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_hold_cycles = 300;
        for (k = 0; k < 40; k++) begin
            if (k % 8 == 7)
                send_tick();
            else
                send_beat(OP_CHANNEL, CH_W'(k), pick_raw(), (k % 8 == 6));
        end
    endtask

    // Mostly well-formed frames with ticks between, some noise, across idling modes
    task automatic test_random_traffic();
        int phase;
        int start;
        int k;
        for (phase = 0; phase < 12; phase++) begin
            random_config();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            start = beats_sent;
            while (beats_sent - start < 100) begin
                case ($urandom_range(9))
                    0: send_beat(1'($urandom), CH_W'($urandom), RX_W'($urandom),
                                 1'($urandom));
                    1, 2: for (k = $urandom_range(1, 3); k > 0; k--) send_tick();
                    3: send_frame(1'b1);
                    default: send_frame(1'b0);
                endcase
            end
        end
    endtask

    // Latch only when a beat checks the timeout, then stay latched through later frames
    task automatic test_failsafe_latch();
        int k;
        set_config(172, 1811, 1000, 2000, 1000, 2000, 40);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_beat(OP_CHANNEL, 4'd0, 11'd992, 1'b1);
        for (k = 0; k < 10; k++) send_tick();
        // timeout lowered below the silence; the next frame end clears it first
        drain();
        program_reg(REG_TIMEOUT, 32'd5);
        send_beat(OP_CHANNEL, 4'd1, 11'd500, 1'b1);
        // latches at the fifth tick
        for (k = 0; k < 8; k++) send_tick();
        send_frame(1'b0);
        send_tick();
    endtask

    // Result checker
    always @(posedge aclk) begin : check_results
        rc_result_t got;
        rc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_channel  = m_tuser;
            got.out_channel = m_tdata[3:0];
            got.pulse_width = m_tdata[15:4];
            got.failsafe    = m_tdata[16];
            got.signal_seen = m_tdata[17];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none actual ch=%0d pw=%0d", $time,
                         got.out_channel, got.pulse_width);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: result mismatch: expected is_ch=%0d ch=%0d pw=%0d fs=%0d seen=%0d",
                             $time, want.is_channel, want.out_channel, want.pulse_width,
                             want.failsafe, want.signal_seen);
                    $display("%0t:                  actual is_ch=%0d ch=%0d pw=%0d fs=%0d seen=%0d",
                             $time, got.is_channel, got.out_channel, got.pulse_width,
                             got.failsafe, got.signal_seen);
                end
            end
        end
    end

    // Receiver ready: long hold-off when requested, else random stalls
    always @(negedge aclk) begin
        if (stall_hold_cycles > 0) begin
            stall_hold_cycles = stall_hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rx_lo      = RST_RX_MIN;
        rx_hi      = RST_RX_MAX;
        pw_lo      = RST_PW_MIN;
        pw_hi      = RST_PW_MAX;
        lim_lo     = RST_FLOOR;
        lim_hi     = RST_CEILING;
        timeout_ms = RST_TIMEOUT;
        silence_ms   = '0;
        frame_seen   = 1'b0;
        failsafe_set = 1'b0;
        mismatch_count    = 0;
        beats_sent        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        stall_hold_cycles = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ticks_without_signal();
        test_directed_mapping();
        test_backpressure();
        test_random_traffic();
        test_failsafe_latch();

        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
sv/rcm_pkg.sv
sv/rc_channel_map_with_failsafe.sv
bench/rc_channel_map_with_failsafe_tb.sv
